>>> design/assert_macros.svh
// Assertion macros shared by the servo trajectory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sst_pkg.sv
// Shared types, codes and helper functions for the servo trajectory unit.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int ANGLE_W     = 9;
  localparam int TARGET_W    = 10;
  localparam int DUR_W       = 16;
  localparam int PULSE_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_AXES    = 3;
  localparam int PULSE_NUM_W = 20;

  typedef logic [ANGLE_W-1:0]         angle_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic [DUR_W-1:0]           dur_t;
  typedef logic [PULSE_W-1:0]         pulse_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // status / done flags of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam status_t ST_ACCEPTED  = 2'd0;
  localparam status_t ST_BUSY      = 2'd1;
  localparam status_t ST_PULSES    = 2'd2;
  localparam status_t ST_IDLE_TICK = 2'd3;

  localparam cfg_idx_t CFG_ROLL_MIN  = 3'd0;
  localparam cfg_idx_t CFG_ROLL_MAX  = 3'd1;
  localparam cfg_idx_t CFG_PITCH_MIN = 3'd2;
  localparam cfg_idx_t CFG_PITCH_MAX = 3'd3;
  localparam cfg_idx_t CFG_YAW_MIN   = 3'd4;
  localparam cfg_idx_t CFG_YAW_MAX   = 3'd5;
  localparam cfg_idx_t CFG_DUR_MIN   = 3'd6;
  localparam cfg_idx_t CFG_DUR_MAX   = 3'd7;

  localparam angle_t RST_ROLL_MIN  = 9'd90;
  localparam angle_t RST_ROLL_MAX  = 9'd180;
  localparam angle_t RST_PITCH_MIN = 9'd10;
  localparam angle_t RST_PITCH_MAX = 9'd60;
  localparam angle_t RST_YAW_MIN   = 9'd90;
  localparam angle_t RST_YAW_MAX   = 9'd180;
  localparam dur_t   RST_DUR_MIN   = 16'd1000;
  localparam dur_t   RST_DUR_MAX   = 16'd10000;
  localparam dur_t   RST_DURATION  = 16'd1000;

  localparam angle_t RST_ROLL_HOME  = 9'd135;
  localparam angle_t RST_PITCH_HOME = 9'd60;
  localparam angle_t RST_YAW_HOME   = 9'd135;

  // pulse = (angle + 1) * 1800 / 271 + 600
  localparam logic [10:0] PULSE_SPAN = 11'd1800;
  localparam dur_t        PULSE_DIV  = 16'd271;
  localparam pulse_t      PULSE_BASE = 12'd600;

  function automatic angle_t clamp_angle(target_t t, angle_t lo, angle_t hi);
    logic signed [TARGET_W:0] v;
    logic signed [TARGET_W:0] l;
    logic signed [TARGET_W:0] h;
    v = {t[TARGET_W-1], t};
    l = {{(TARGET_W+1-ANGLE_W){1'b0}}, lo};
    h = {{(TARGET_W+1-ANGLE_W){1'b0}}, hi};
    if (v < l) v = l;
    if (v > h) v = h;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic dur_t clamp_dur(dur_t v, dur_t lo, dur_t hi);
    dur_t r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

>>> design/sst_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module sst_mul #(
  parameter int A_W = 17,
  parameter int B_W = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [A_W-1:0]         a,
  input  logic [B_W-1:0]         b,
  output logic [A_W+B_W-1:0]     p,
  output sst_pkg::unit_sts_t     sts
);
  import sst_pkg::*;

  localparam int C_W = $clog2(B_W + 1);

  logic [A_W-1:0] mcand;
  logic [A_W-1:0] hi;
  logic [B_W-1:0] lo;
  logic [C_W-1:0] cnt;
  logic [A_W:0]   sum;

  // add multiplicand into the upper half when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign p   = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      // done pulses for one cycle after the last step
      sts.done <= !start && sts.busy && (cnt == C_W'(1));
      if (start) begin
        mcand    <= a;
        hi       <= '0;
        lo       <= b;
        cnt      <= C_W'(B_W);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        hi  <= sum[A_W:1];
        lo  <= {sum[0], lo[B_W-1:1]};
        cnt <= cnt - C_W'(1);
        if (cnt == C_W'(1)) begin
          sts.busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> design/sst_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sst_div #(
  parameter int Q_W = 20,
  parameter int D_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [Q_W-1:0]     num,
  input  logic [D_W-1:0]     rem_init,
  input  logic [D_W-1:0]     den,
  output logic [Q_W-1:0]     q,
  output sst_pkg::unit_sts_t sts
);
  import sst_pkg::*;

  localparam int C_W = $clog2(Q_W + 1);

  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [Q_W-1:0] acc;
  logic [C_W-1:0] cnt;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           fits;

  // dividend bits leave at the top of acc, quotient bits enter at the bottom
  assign trial = {rem, acc[Q_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};
  assign q     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      // done pulses for one cycle after the last step
      sts.done <= !start && sts.busy && (cnt == C_W'(1));
      if (start) begin
        rem      <= rem_init;
        dvs      <= den;
        acc      <= num;
        cnt      <= C_W'(Q_W);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
        acc <= {acc[Q_W-2:0], fits};
        cnt <= cnt - C_W'(1);
        if (cnt == C_W'(1)) begin
          sts.busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> design/smootherstep_servo_trajectory_unit.sv
// Top level: three-axis smootherstep servo trajectory generator.
//
// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------------
// cmd      cmd_valid / cmd_stall  command, roll/pitch/yaw_target, move_duration_ms
// rsp      rsp_valid / rsp_stall  status, roll/pitch/yaw_pulse_us, motion_done,
//                                 roll/pitch/yaw_goal
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Move, refused move and idle tick: result registered in the cycle after the transaction.
// Pulse tick: computed on one shared bit-serial multiplier (six products) and one
//   restoring divider (four quotients).
// Reset restores config limits, home angles and duration; no clearing pass.
// One transaction in flight; cmd_stall stays high until the result register can
//   take the answer, and a stalled rsp holds its payload.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smootherstep_servo_trajectory_unit #(
  parameter int TICK_MS       = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  command,
  input  sst_pkg::target_t      roll_target,
  input  sst_pkg::target_t      pitch_target,
  input  sst_pkg::target_t      yaw_target,
  input  sst_pkg::dur_t         move_duration_ms,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sst_pkg::status_t      status,
  output sst_pkg::pulse_t       roll_pulse_us,
  output sst_pkg::pulse_t       pitch_pulse_us,
  output sst_pkg::pulse_t       yaw_pulse_us,
  output logic                  motion_done,
  output sst_pkg::angle_t       roll_goal,
  output sst_pkg::angle_t       pitch_goal,
  output sst_pkg::angle_t       yaw_goal,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sst_pkg::cfg_idx_t     cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sst_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int QW = (F > PULSE_NUM_W) ? F : PULSE_NUM_W;  // divider quotient width
  localparam int MA = F + 1;                                 // multiplicand width
  localparam int MB = F + 4;                                 // multiplier width
  localparam int MW = MA + MB;
  localparam int PW = F + 4;                                 // p polynomial width
  localparam int SW = F + 1;                                 // smootherstep, 0..1.0

  localparam logic [PW:0]   TEN_Q = (PW+1)'(64'd10 << F);
  localparam logic [F+4:0]  Q_ONE = (F+5)'(64'd1 << F);
  localparam logic [MW:0]   Q_M1  = (MW+1)'((64'd1 << F) - 64'd1);
  localparam logic [1:0]    LAST_AXIS = 2'(NUM_AXES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;  // x = elapsed / duration
  localparam logic [2:0] S_MXX  = 3'd2;  // x * x
  localparam logic [2:0] S_MX3  = 3'd3;  // x^2 * x
  localparam logic [2:0] S_MS   = 3'd4;  // x^3 * p
  localparam logic [2:0] S_MD   = 3'd5;  // s * |goal - start|, per axis
  localparam logic [2:0] S_DIVP = 3'd6;  // angle to pulse, per axis
  localparam logic [2:0] S_OUT  = 3'd7;

  // config registers
  angle_t roll_min_angle, roll_max_angle;
  angle_t pitch_min_angle, pitch_max_angle;
  angle_t yaw_min_angle, yaw_max_angle;
  dur_t   min_duration_ms, max_duration_ms;

  // motion state
  angle_t start_angle [NUM_AXES];
  angle_t goal_angle  [NUM_AXES];
  dur_t   duration;
  dur_t   elapsed;
  logic   moving;

  // tick working registers
  logic [2:0]    state;
  logic [1:0]    ax;
  logic [F-1:0]  x_q;
  logic [PW-1:0] p_q;
  logic [SW-1:0] s_q;
  pulse_t        pulse_q [NUM_AXES];

  // handshake
  logic slot_free;
  logic cmd_accept;
  logic rsp_load;

  // unit hookup
  logic            mul_start;
  logic [MA-1:0]   mul_a;
  logic [MB-1:0]   mul_b;
  logic [MW-1:0]   mul_p;
  unit_sts_t       mul_sts;
  logic            div_start;
  logic [QW-1:0]   div_num;
  dur_t            div_rem;
  dur_t            div_den;
  logic [QW-1:0]   div_q;
  unit_sts_t       div_sts;

  // datapath between unit results and registers
  angle_t          goal_clamp [NUM_AXES];
  dur_t            dur_clamp;
  logic [F-1:0]    x_new;
  logic [F-1:0]    x2_new;
  logic [F-1:0]    x3_new;
  logic [2*F+2:0]  six_xx;
  logic [PW:0]     p_new;
  logic [F+4:0]    s_full;
  logic [SW-1:0]   s_new;
  logic [1:0]      d_sel;
  angle_t          a0, a1, d_mag;
  logic            d_neg;
  logic [MW:0]     dec_sum;
  logic [F+5:0]    dec_full;
  logic [F+4:0]    inc_full;
  angle_t          angle_new;
  logic [ANGLE_W:0] ap1;
  logic [PULSE_NUM_W-1:0] pulse_num;
  pulse_t          pulse_val;
  logic [DUR_W:0]  el_sum;
  logic            tick_done;
  dur_t            el_sat;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall  = !(state == S_IDLE && slot_free);
  assign cmd_accept = cmd_valid && !cmd_stall;

  // result register loads: immediate answers, or the finished pulse tick
  assign rsp_load = (cmd_accept && (command == CMD_MOVE || !moving))
                  || (state == S_OUT && slot_free);

  // move: clamp targets and duration
  assign goal_clamp[0] = clamp_angle(roll_target,  roll_min_angle,  roll_max_angle);
  assign goal_clamp[1] = clamp_angle(pitch_target, pitch_min_angle, pitch_max_angle);
  assign goal_clamp[2] = clamp_angle(yaw_target,   yaw_min_angle,   yaw_max_angle);
  assign dur_clamp     = clamp_dur(move_duration_ms, min_duration_ms, max_duration_ms);

  // fraction of the move, Q0.F; elapsed < duration while moving so x < 1.0
  assign x_new  = div_q[QW-1 -: F];
  assign x2_new = mul_p[2*F-1:F];
  assign x3_new = mul_p[2*F-1:F];

  // p = 10 - 15x + 6x^2, the 6x^2 term floored once
  assign six_xx = {1'b0, mul_p[2*F-1:0], 2'b00} + {2'b00, mul_p[2*F-1:0], 1'b0};
  assign p_new  = TEN_Q + (PW+1)'(six_xx[2*F+2:F]) + (PW+1)'(x_q)
                - {1'b0, x_q, 4'b0000};

  // s = x^3 * p, limited to 1.0
  assign s_full = mul_p[MW-1:F];
  assign s_new  = (s_full > Q_ONE) ? Q_ONE[SW-1:0] : s_full[SW-1:0];

  // axis select: next axis while finishing the pulse division of this one
  assign d_sel = (state == S_DIVP) ? ax + 2'd1 : ax;

  always_comb begin
    case (d_sel)
      2'd1: begin
        a0 = start_angle[1];
        a1 = goal_angle[1];
      end
      2'd2: begin
        a0 = start_angle[2];
        a1 = goal_angle[2];
      end
      default: begin
        a0 = start_angle[0];
        a1 = goal_angle[0];
      end
    endcase
  end

  assign d_neg = a1 < a0;
  assign d_mag = d_neg ? a0 - a1 : a1 - a0;

  // blend: floor toward the goal going up, ceiling of the step going down
  assign inc_full = mul_p[MW-1:F];
  assign dec_sum  = {1'b0, mul_p} + Q_M1;
  assign dec_full = dec_sum[MW:F];

  always_comb begin
    if (!d_neg) begin
      angle_new = a0 + inc_full[ANGLE_W-1:0];
    end else if (dec_full > (F+6)'(a0)) begin
      angle_new = '0;
    end else begin
      angle_new = a0 - dec_full[ANGLE_W-1:0];
    end
  end

  assign ap1       = {1'b0, angle_new} + (ANGLE_W+1)'(1);
  assign pulse_num = PULSE_NUM_W'(ap1) * PULSE_NUM_W'(PULSE_SPAN);
  assign pulse_val = div_q[PULSE_W-1:0] + PULSE_BASE;

  // elapsed advance, saturating
  assign el_sum    = {1'b0, elapsed} + (DUR_W+1)'(TICK_MS);
  assign tick_done = el_sum >= {1'b0, duration};
  assign el_sat    = el_sum[DUR_W] ? '1 : el_sum[DUR_W-1:0];

  // unit launch and operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_rem   = '0;
    div_den   = '0;
    case (state)
      S_IDLE: begin
        if (cmd_accept && command == CMD_TICK && moving) begin
          div_start = 1'b1;
          div_rem   = elapsed;
          div_den   = duration;
        end
      end
      S_DIVX: begin
        if (div_sts.done) begin
          mul_start = 1'b1;
          mul_a     = MA'(x_new);
          mul_b     = MB'(x_new);
        end
      end
      S_MXX: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          mul_a     = MA'(x2_new);
          mul_b     = MB'(x_q);
        end
      end
      S_MX3: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          mul_a     = MA'(x3_new);
          mul_b     = p_q;
        end
      end
      S_MS: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          mul_a     = s_new;
          mul_b     = MB'(d_mag);
        end
      end
      S_MD: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          div_num   = QW'(pulse_num);
          div_den   = PULSE_DIV;
        end
      end
      S_DIVP: begin
        if (div_sts.done && ax != LAST_AXIS) begin
          mul_start = 1'b1;
          mul_a     = s_q;
          mul_b     = MB'(d_mag);
        end
      end
      default: begin
      end
    endcase
  end

  sst_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .sts   (mul_sts)
  );

  sst_div #(
    .Q_W (QW),
    .D_W (DUR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .rem_init (div_rem),
    .den      (div_den),
    .q        (div_q),
    .sts      (div_sts)
  );

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ax              <= '0;
      rsp_valid       <= 1'b0;
      roll_min_angle  <= RST_ROLL_MIN;
      roll_max_angle  <= RST_ROLL_MAX;
      pitch_min_angle <= RST_PITCH_MIN;
      pitch_max_angle <= RST_PITCH_MAX;
      yaw_min_angle   <= RST_YAW_MIN;
      yaw_max_angle   <= RST_YAW_MAX;
      min_duration_ms <= RST_DUR_MIN;
      max_duration_ms <= RST_DUR_MAX;
      start_angle[0]  <= RST_ROLL_HOME;
      start_angle[1]  <= RST_PITCH_HOME;
      start_angle[2]  <= RST_YAW_HOME;
      goal_angle[0]   <= RST_ROLL_HOME;
      goal_angle[1]   <= RST_PITCH_HOME;
      goal_angle[2]   <= RST_YAW_HOME;
      duration        <= RST_DURATION;
      elapsed         <= '0;
      moving          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROLL_MIN:  roll_min_angle  <= cfg_data[ANGLE_W-1:0];
          CFG_ROLL_MAX:  roll_max_angle  <= cfg_data[ANGLE_W-1:0];
          CFG_PITCH_MIN: pitch_min_angle <= cfg_data[ANGLE_W-1:0];
          CFG_PITCH_MAX: pitch_max_angle <= cfg_data[ANGLE_W-1:0];
          CFG_YAW_MIN:   yaw_min_angle   <= cfg_data[ANGLE_W-1:0];
          CFG_YAW_MAX:   yaw_max_angle   <= cfg_data[ANGLE_W-1:0];
          CFG_DUR_MIN:   min_duration_ms <= cfg_data[DUR_W-1:0];
          CFG_DUR_MAX:   max_duration_ms <= cfg_data[DUR_W-1:0];
          default: begin
          end
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            if (command == CMD_MOVE) begin
              roll_pulse_us  <= '0;
              pitch_pulse_us <= '0;
              yaw_pulse_us   <= '0;
              motion_done    <= 1'b0;
              if (moving) begin
                status     <= ST_BUSY;
                roll_goal  <= goal_angle[0];
                pitch_goal <= goal_angle[1];
                yaw_goal   <= goal_angle[2];
              end else begin
                status        <= ST_ACCEPTED;
                roll_goal     <= goal_clamp[0];
                pitch_goal    <= goal_clamp[1];
                yaw_goal      <= goal_clamp[2];
                goal_angle[0] <= goal_clamp[0];
                goal_angle[1] <= goal_clamp[1];
                goal_angle[2] <= goal_clamp[2];
                duration      <= dur_clamp;
                elapsed       <= '0;
                // zero duration completes at once
                if (dur_clamp == '0) begin
                  start_angle[0] <= goal_clamp[0];
                  start_angle[1] <= goal_clamp[1];
                  start_angle[2] <= goal_clamp[2];
                  moving         <= 1'b0;
                end else begin
                  moving <= 1'b1;
                end
              end
            end else if (!moving) begin
              status         <= ST_IDLE_TICK;
              roll_pulse_us  <= '0;
              pitch_pulse_us <= '0;
              yaw_pulse_us   <= '0;
              motion_done    <= 1'b0;
              roll_goal      <= goal_angle[0];
              pitch_goal     <= goal_angle[1];
              yaw_goal       <= goal_angle[2];
            end else begin
              ax    <= '0;
              state <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_sts.done) begin
            x_q   <= x_new;
            state <= S_MXX;
          end
        end
        S_MXX: begin
          if (mul_sts.done) begin
            p_q   <= p_new[PW-1:0];
            state <= S_MX3;
          end
        end
        S_MX3: begin
          if (mul_sts.done) state <= S_MS;
        end
        S_MS: begin
          if (mul_sts.done) begin
            s_q   <= s_new;
            state <= S_MD;
          end
        end
        S_MD: begin
          if (mul_sts.done) state <= S_DIVP;
        end
        S_DIVP: begin
          if (div_sts.done) begin
            pulse_q[ax] <= pulse_val;
            if (ax == LAST_AXIS) begin
              state <= S_OUT;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_MD;
            end
          end
        end
        S_OUT: begin
          if (slot_free) begin
            status         <= ST_PULSES;
            roll_pulse_us  <= pulse_q[0];
            pitch_pulse_us <= pulse_q[1];
            yaw_pulse_us   <= pulse_q[2];
            motion_done    <= tick_done;
            roll_goal      <= goal_angle[0];
            pitch_goal     <= goal_angle[1];
            yaw_goal       <= goal_angle[2];
            elapsed        <= el_sat;
            if (tick_done) begin
              start_angle[0] <= goal_angle[0];
              start_angle[1] <= goal_angle[1];
              start_angle[2] <= goal_angle[2];
              moving         <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SST_ASSERT_ALWAYS(a_one_unit_busy, !(mul_sts.busy && div_sts.busy), "both units busy")
  `SST_ASSERT_IMPL(a_work_only_moving, state != S_IDLE, moving, "tick work without motion")
  `SST_ASSERT_IMPL(a_done_ends_motion, rsp_valid && motion_done, !moving, "done but moving")
  `SST_ASSERT_IMPL(a_quiet_pulses, rsp_valid && status != ST_PULSES, roll_pulse_us == '0 && pitch_pulse_us == '0 && yaw_pulse_us == '0 && !motion_done, "pulses on non-pulse result")
  `SST_ASSERT_NEXT(a_tick_launch, cmd_accept && command == CMD_TICK && moving, state == S_DIVX && div_sts.busy, "tick did not start divider")

endmodule
